### rtl/smf_pkg.sv
package smf_pkg;

  localparam int MAX_QUERY_DEF   = 32;
  localparam int MAX_MATCHES_DEF = 65536;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int QUERY_BYTES = 32;
  localparam int QUERY_WORDS = 4;
  localparam int QLEN_W      = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int S_TDATA_W   = 8;
  localparam int OUT_OFS_W   = 32;
  localparam int TOTAL_W     = 17;
  localparam int M_TDATA_W   = 88;
  localparam int QFIFO_DEPTH = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_QWORD0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QWORD1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_QWORD2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_QWORD3 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_QLEN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOCASE = 3'd5;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [QUERY_BYTES*8-1:0] query;
    logic [QLEN_W-1:0]        qlen;
    logic                     nocase;
  } smf_cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [OUT_OFS_W-1:0] match_start;
    logic [OUT_OFS_W-1:0] match_end;
    logic [TOTAL_W-1:0]   match_total;
    logic                 cap_reached;
    logic                 last_result;
  } smf_result_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic nocase);
    logic upper;
    upper = (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z);
    return (nocase && upper) ? b + ASCII_CASE_OFS : b;
  endfunction

endpackage

### rtl/substring_match_finder_unit.sv
// Streaming substring finder.
// Input stream: one buffer byte per word on s_tdata, s_tlast on the final
// byte of a buffer. Output stream: match words (m_tuser = 0) carrying start
// offset, end offset (one past the last byte), running match count and the
// cap flag; on the last byte of a buffer a summary word (m_tuser = 1)
// follows. m_tlast marks the final word produced for an input byte.
// Matches are leftmost and non-overlapping; scanning resumes at the end of
// the previous match.
// Configuration: cfg_wen/cfg_addr/cfg_wdata write query words 0-3, the
// query length and the case-fold enable; write only while idle.
// Throughput: one byte per cycle while the output is not stalled; a byte
// yielding both a match and a summary sends both words through the output register in turn.
// The first word for a byte passes the window compare stage, a queue entry
// and then the result register before it is valid.
// A 4-entry queue sits between the compare stage and the match tracker, so
// an output stall backs up into the queue before s_tready falls.
// Reset clears the control state and the configuration; case folding resets to on.
module substring_match_finder_unit
  import smf_pkg::*;
#(
  parameter int MAX_QUERY   = MAX_QUERY_DEF,
  parameter int MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // input_byte
  input  logic                  s_tlast,   // end_of_buffer
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // match_start, match_end, match_total, cap_reached
  output logic                  m_tuser,   // kind
  output logic                  m_tlast,   // last_result
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int EW = 2 * OFFSET_BITS + 2;

  logic [CFG_DATA_W-1:0] qword [QUERY_WORDS];
  logic [QLEN_W-1:0]     qlen;
  logic                  nocase;
  smf_cfg_t              cfg;

  logic          push_valid;
  logic          push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [EW-1:0] pop_data;
  smf_result_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUERY_WORDS; k++) begin
        qword[k] <= '0;
      end
      qlen   <= '0;
      nocase <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_QWORD0: qword[0] <= cfg_wdata;
        CFG_QWORD1: qword[1] <= cfg_wdata;
        CFG_QWORD2: qword[2] <= cfg_wdata;
        CFG_QWORD3: qword[3] <= cfg_wdata;
        CFG_QLEN:   qlen     <= cfg_wdata[QLEN_W-1:0];
        CFG_NOCASE: nocase   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.query  = {qword[3], qword[2], qword[1], qword[0]};
  assign cfg.qlen   = qlen;
  assign cfg.nocase = nocase;

  smf_front #(
    .MAX_QUERY   (MAX_QUERY),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eob     (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  smf_fifo #(
    .WIDTH (EW),
    .DEPTH (QFIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  smf_back #(
    .MAX_MATCHES (MAX_MATCHES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_data   (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {6'b0, res.cap_reached, res.match_total, res.match_end, res.match_start};
  assign m_tuser = res.kind;
  assign m_tlast = res.last_result;

endmodule

### rtl/smf_fifo.sv
module smf_fifo
  import smf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QFIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/smf_front.sv
module smf_front
  import smf_pkg::*;
#(
  parameter int MAX_QUERY   = MAX_QUERY_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smf_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_eob,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [2*OFFSET_BITS+1:0] push_data
);

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

  logic [7:0]             win [MAX_QUERY];
  logic [OFFSET_BITS-1:0] pos;
  logic                   s1_valid;
  logic [OFFSET_BITS-1:0] s1_pos;
  logic                   s1_eob;
  logic                   take;
  logic [MAX_QUERY-1:0]   lane_ok;
  logic [OFFSET_BITS-1:0] p1;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] qlen_ext;
  logic                   cand;

  assign in_ready = !s1_valid || push_ready;
  assign take     = in_valid && in_ready;

  // newest byte at lane 0
  always_ff @(posedge clk) begin
    if (take) begin
      win[0] <= in_byte;
      for (int k = 1; k < MAX_QUERY; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
        s1_pos   <= pos;
        s1_eob   <= in_eob;
        if (in_eob) begin
          pos <= '0;
        end else if (pos != OFS_MAX) begin
          pos <= pos + OFFSET_BITS'(1);
        end
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // lane j holds the byte that must equal query byte qlen-1-j
  for (genvar j = 0; j < MAX_QUERY; j++) begin : g_lane
    logic [QLEN_W-1:0] qidx;
    logic [7:0]        qbyte;
    assign qidx  = cfg.qlen - QLEN_W'(j + 1);
    assign qbyte = cfg.query[qidx[4:0]*8 +: 8];
    assign lane_ok[j] = (QLEN_W'(j) >= cfg.qlen) ||
                        (fold_byte(win[j], cfg.nocase) == fold_byte(qbyte, cfg.nocase));
  end

  assign qlen_ext = OFFSET_BITS'(cfg.qlen);
  assign p1       = s1_pos + OFFSET_BITS'(1);
  assign start    = p1 - qlen_ext;
  assign cand     = (&lane_ok) && (cfg.qlen != '0) &&
                    (cfg.qlen <= QLEN_W'(MAX_QUERY)) &&
                    (s1_pos != OFS_MAX) && (p1 >= qlen_ext);

  assign push_valid = s1_valid;
  assign push_data  = {s1_eob, cand, p1, start};

endmodule

### rtl/smf_back.sv
module smf_back
  import smf_pkg::*;
#(
  parameter int MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2*OFFSET_BITS+1:0] in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output smf_result_t              out_res
);

  localparam int CW = $clog2(MAX_MATCHES + 1);

  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_inc;
  logic [OFFSET_BITS-1:0] nas;
  logic                   cap;
  logic                   phase;
  logic                   res_valid;
  smf_result_t            res;

  logic [OFFSET_BITS-1:0] h_start;
  logic [OFFSET_BITS-1:0] h_end;
  logic                   h_cand;
  logic                   h_eob;
  logic                   room;
  logic                   take;
  logic                   hit;
  logic                   full;
  logic                   acc;
  logic                   capset;

  assign {h_eob, h_cand, h_end, h_start} = in_data;

  assign cnt_inc = cnt + CW'(1);
  assign room    = !res_valid || out_ready;
  assign take    = in_valid && room;
  assign hit     = !phase && h_cand && (h_start >= nas) && !cap;
  assign full    = (cnt >= CW'(MAX_MATCHES));
  assign acc     = hit && !full;
  assign capset  = hit && full;

  // a match on the last byte holds the entry for a second word
  assign in_ready = take && !(acc && h_eob);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      nas       <= '0;
      cap       <= 1'b0;
      phase     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take && (phase || h_eob || acc)) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        if (phase || h_eob && !acc) begin
          res.kind        <= KIND_SUMMARY;
          res.match_start <= '0;
          res.match_end   <= '0;
          res.match_total <= TOTAL_W'(cnt);
          res.cap_reached <= cap || capset;
          res.last_result <= 1'b1;
          cnt             <= '0;
          nas             <= '0;
          cap             <= 1'b0;
          phase           <= 1'b0;
        end else if (acc) begin
          res.kind        <= KIND_MATCH;
          res.match_start <= OUT_OFS_W'(h_start);
          res.match_end   <= OUT_OFS_W'(h_end);
          res.match_total <= TOTAL_W'(cnt_inc);
          res.cap_reached <= cap;
          res.last_result <= !h_eob;
          cnt             <= cnt_inc;
          nas             <= h_end;
          phase           <= h_eob;
        end else if (capset) begin
          cap <= 1'b1;
        end
      end
    end
  end

  assign out_valid = res_valid;
  assign out_res   = res;

endmodule
